// ===== rtl/vcl_pkg.sv =====
// Shared types, constants and helpers for the velocity command limiter.
`default_nettype none
package vcl_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_SPEED_LIMIT      = 2'd0;
    localparam logic [1:0] CFG_ACCEL_LIMIT      = 2'd1;
    localparam logic [1:0] CFG_TURN_RATE_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_TURN_ACCEL_LIMIT = 2'd3;

    localparam logic [14:0] LIMIT_RESET = 15'd4096;

    // Square root and divider chain sizes.
    localparam int SQ1_N   = 24;   // speed magnitude root bits
    localparam int DIV1_NW = 39;   // speed scaling numerator bits
    localparam int DIV1_Q  = 16;   // speed scaling quotient bits
    localparam int SQ2_N   = 25;   // velocity change magnitude root bits
    localparam int DIV2_NW = 48;   // acceleration step numerator bits
    localparam int DIV2_VW = 33;   // acceleration step divisor bits
    localparam int DIV2_Q  = 18;   // acceleration step quotient bits

    // Sideband carried alongside the speed magnitude root.
    typedef struct packed {
        logic               held;
        logic               spd_over;
        logic               rot_cap;
        logic               sgn_x;
        logic               sgn_y;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] rot;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cr;
        logic [15:0]        t;
        logic [30:0]        nx;
        logic [30:0]        ny;
    } spd_side_t;

    // Sideband carried alongside the speed scaling divider.
    typedef struct packed {
        logic               held;
        logic               spd_over;
        logic               rot_cap;
        logic               sgn_x;
        logic               sgn_y;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] rot;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cr;
        logic [15:0]        t;
    } spd_div_side_t;

    // Sideband carried alongside the velocity change magnitude root.
    typedef struct packed {
        logic               held;
        logic               scap;
        logic               ra_over;
        logic               tr_over;
        logic               sgn_x;
        logic               sgn_y;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] rot;
        logic [46:0]        ax;
        logic [46:0]        ay;
    } acc_side_t;

    // Sideband carried alongside the acceleration step divider.
    typedef struct packed {
        logic               held;
        logic               scap;
        logic               ra_over;
        logic               tr_over;
        logic               sgn_x;
        logic               sgn_y;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] rot;
    } acc_div_side_t;

    // Saturate a wide signed value to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -20'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vcl_sqrt_cell.sv =====
// One registered digit cell of a pipelined integer square root.
`default_nettype none
module vcl_sqrt_cell #(
    parameter int N  = 24,
    parameter int SW = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [2*N-1:0] in_rad,
    input  logic [N:0]     in_rem,
    input  logic [N-1:0]   in_root,
    input  logic [SW-1:0]  in_side,
    output logic           out_valid,
    output logic [2*N-1:0] out_rad,
    output logic [N:0]     out_rem,
    output logic [N-1:0]   out_root,
    output logic [SW-1:0]  out_side
);

    logic           valid_reg;
    logic [2*N-1:0] rad_reg;
    logic [N:0]     rem_reg;
    logic [N-1:0]   root_reg;
    logic [SW-1:0]  side_reg;
    logic [N+2:0]   rem_t;
    logic [N+2:0]   trial;
    logic [N+2:0]   rem_diff;
    logic           ge;

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_t    = {in_rem, in_rad[2*N-1 -: 2]};
    assign trial    = {1'b0, in_root, 2'b01};
    assign ge       = (rem_t >= trial);
    assign rem_diff = rem_t - trial;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Partial root, remainder and carried data.
    always_ff @(posedge clk)
    begin
        rad_reg  <= {in_rad[2*N-3:0], 2'b00};
        rem_reg  <= ge ? rem_diff[N:0] : rem_t[N:0];
        root_reg <= {in_root[N-2:0], ge};
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

// ===== rtl/vcl_div_cell.sv =====
// One registered quotient-bit cell of a pipelined divider with two numerators.
`default_nettype none
module vcl_div_cell #(
    parameter int NW    = 39,
    parameter int VW    = 24,
    parameter int QW    = 16,
    parameter int SHIFT = 0,
    parameter int SW    = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num_x,
    input  logic [NW-1:0] in_num_y,
    input  logic [VW-1:0] in_den,
    input  logic [QW-1:0] in_qx,
    input  logic [QW-1:0] in_qy,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_num_x,
    output logic [NW-1:0] out_num_y,
    output logic [VW-1:0] out_den,
    output logic [QW-1:0] out_qx,
    output logic [QW-1:0] out_qy,
    output logic [SW-1:0] out_side
);

    localparam int TW = (VW + SHIFT > NW) ? VW + SHIFT : NW;

    logic          valid_reg;
    logic [NW-1:0] num_x_reg;
    logic [NW-1:0] num_y_reg;
    logic [VW-1:0] den_reg;
    logic [QW-1:0] qx_reg;
    logic [QW-1:0] qy_reg;
    logic [SW-1:0] side_reg;
    logic [TW-1:0] den_sh;
    logic [TW-1:0] nx_w;
    logic [TW-1:0] ny_w;
    logic [TW-1:0] diff_x;
    logic [TW-1:0] diff_y;
    logic          ge_x;
    logic          ge_y;

    // Compare both partial remainders against the shifted divisor.
    assign den_sh = TW'(in_den) << SHIFT;
    assign nx_w   = TW'(in_num_x);
    assign ny_w   = TW'(in_num_y);
    assign ge_x   = (nx_w >= den_sh);
    assign ge_y   = (ny_w >= den_sh);
    assign diff_x = nx_w - den_sh;
    assign diff_y = ny_w - den_sh;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Remainders, quotient bits and carried data.
    always_ff @(posedge clk)
    begin
        num_x_reg <= ge_x ? diff_x[NW-1:0] : in_num_x;
        num_y_reg <= ge_y ? diff_y[NW-1:0] : in_num_y;
        den_reg   <= in_den;
        qx_reg    <= {in_qx[QW-2:0], ge_x};
        qy_reg    <= {in_qy[QW-2:0], ge_y};
        side_reg  <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_num_x = num_x_reg;
    assign out_num_y = num_y_reg;
    assign out_den   = den_reg;
    assign out_qx    = qx_reg;
    assign out_qy    = qy_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

// ===== rtl/velocity_command_limiter_core.sv =====
// Top level of the velocity command limiter: speed and acceleration caps.
//
//  channel   handshake           payload
//  --------  ------------------  -------------------------------------------------
//  command   start / busy        cmd_vx cmd_vy cmd_rot cur_vx cur_vy cur_rot step_time
//  result    done (strobe)       out_vx out_vy out_rot speed_capped accel_capped
//                                held_current
//  config    cfg_we              cfg_addr cfg_wdata
//
// One beat is taken every cycle while busy is low; each result passes through
// the two root chains (24 and 25 cells) and the two divider chains
// (16 and 18 cells) plus nine arithmetic stages.
// busy is high during reset and in the first cycle after it, then stays low.
// The result strobe lasts one cycle; the receiver cannot stall the pipeline.
`default_nettype none
module velocity_command_limiter_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] cmd_vx,
    input  logic signed [15:0] cmd_vy,
    input  logic signed [15:0] cmd_rot,
    input  logic signed [15:0] cur_vx,
    input  logic signed [15:0] cur_vy,
    input  logic signed [15:0] cur_rot,
    input  logic [15:0]        step_time,
    output logic               done,
    output logic signed [15:0] out_vx,
    output logic signed [15:0] out_vy,
    output logic signed [15:0] out_rot,
    output logic               speed_capped,
    output logic               accel_capped,
    output logic               held_current,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [14:0]        cfg_wdata
);

    import vcl_pkg::*;

    localparam int LAT = 9 + SQ1_N + DIV1_Q + SQ2_N + DIV2_Q;

    // ------------------------------------------------------------------
    // Configuration registers and handshake.
    logic [14:0] speed_limit_reg;
    logic [14:0] accel_limit_reg;
    logic [14:0] turn_rate_limit_reg;
    logic [14:0] turn_accel_limit_reg;
    logic        busy_reg;
    logic        in_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg      <= LIMIT_RESET;
            accel_limit_reg      <= LIMIT_RESET;
            turn_rate_limit_reg  <= LIMIT_RESET;
            turn_accel_limit_reg <= LIMIT_RESET;
            busy_reg             <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_SPEED_LIMIT:      speed_limit_reg      <= cfg_wdata;
                    CFG_ACCEL_LIMIT:      accel_limit_reg      <= cfg_wdata;
                    CFG_TURN_RATE_LIMIT:  turn_rate_limit_reg  <= cfg_wdata;
                    CFG_TURN_ACCEL_LIMIT: turn_accel_limit_reg <= cfg_wdata;
                    default:              ;
                endcase
            end
        end
    end

    assign busy   = busy_reg;
    assign in_acc = start & ~busy_reg;

    // ------------------------------------------------------------------
    // Stage 1: squares, numerators of the speed scaling, rotation clamp.
    logic [15:0]        abs_vx;
    logic [15:0]        abs_vy;
    logic [15:0]        abs_rot;
    logic signed [31:0] sqx_prod;
    logic signed [31:0] sqy_prod;
    logic               rot_cap;
    logic signed [15:0] rot_pos;
    logic signed [15:0] rot_l;
    logic               s1_valid_reg;
    logic [30:0]        s1_sqx_reg;
    logic [30:0]        s1_sqy_reg;
    logic [29:0]        s1_l2_reg;
    spd_side_t          s1_side_reg;
    spd_side_t          s1_side_next;

    assign abs_vx   = cmd_vx[15]  ? (~cmd_vx + 16'd1)  : cmd_vx;
    assign abs_vy   = cmd_vy[15]  ? (~cmd_vy + 16'd1)  : cmd_vy;
    assign abs_rot  = cmd_rot[15] ? (~cmd_rot + 16'd1) : cmd_rot;
    assign sqx_prod = cmd_vx * cmd_vx;
    assign sqy_prod = cmd_vy * cmd_vy;
    assign rot_cap  = (abs_rot > {1'b0, turn_rate_limit_reg});
    assign rot_pos  = {1'b0, turn_rate_limit_reg};
    assign rot_l    = rot_cap ? (cmd_rot[15] ? -rot_pos : rot_pos) : cmd_rot;

    always_comb
    begin
        s1_side_next          = '0;
        s1_side_next.held     = (step_time == 16'd0);
        s1_side_next.rot_cap  = rot_cap;
        s1_side_next.sgn_x    = cmd_vx[15];
        s1_side_next.sgn_y    = cmd_vy[15];
        s1_side_next.vx       = cmd_vx;
        s1_side_next.vy       = cmd_vy;
        s1_side_next.rot      = rot_l;
        s1_side_next.cx       = cur_vx;
        s1_side_next.cy       = cur_vy;
        s1_side_next.cr       = cur_rot;
        s1_side_next.t        = step_time;
        s1_side_next.nx       = abs_vx * speed_limit_reg;
        s1_side_next.ny       = abs_vy * speed_limit_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_sqx_reg  <= sqx_prod[30:0];
        s1_sqy_reg  <= sqy_prod[30:0];
        s1_l2_reg   <= speed_limit_reg * speed_limit_reg;
        s1_side_reg <= s1_side_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: squared speed and the speed limit test.
    logic        s2_valid_reg;
    logic [31:0] s2_sum_reg;
    spd_side_t   s2_side_reg;
    spd_side_t   s2_side_next;
    logic [31:0] s2_sum;

    assign s2_sum = {1'b0, s1_sqx_reg} + {1'b0, s1_sqy_reg};

    always_comb
    begin
        s2_side_next          = s1_side_reg;
        s2_side_next.spd_over = (s2_sum > {2'b00, s1_l2_reg});
    end

    always_ff @(posedge clk)
    begin
        s2_sum_reg  <= s2_sum;
        s2_side_reg <= s2_side_next;
    end

    // ------------------------------------------------------------------
    // Speed magnitude root chain.
    logic             sq1_valid [0:SQ1_N];
    logic [2*SQ1_N-1:0] sq1_rad [0:SQ1_N];
    logic [SQ1_N:0]   sq1_rem   [0:SQ1_N];
    logic [SQ1_N-1:0] sq1_root  [0:SQ1_N];
    spd_side_t        sq1_side  [0:SQ1_N];

    assign sq1_valid[0] = s2_valid_reg;
    assign sq1_rad[0]   = {s2_sum_reg, 16'h0000};
    assign sq1_rem[0]   = '0;
    assign sq1_root[0]  = '0;
    assign sq1_side[0]  = s2_side_reg;

    for (genvar g = 0; g < SQ1_N; g++)
    begin : g_sq1
        vcl_sqrt_cell #(
            .N  (SQ1_N),
            .SW ($bits(spd_side_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq1_valid[g]),
            .in_rad    (sq1_rad[g]),
            .in_rem    (sq1_rem[g]),
            .in_root   (sq1_root[g]),
            .in_side   (sq1_side[g]),
            .out_valid (sq1_valid[g+1]),
            .out_rad   (sq1_rad[g+1]),
            .out_rem   (sq1_rem[g+1]),
            .out_root  (sq1_root[g+1]),
            .out_side  (sq1_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage 3: rounded numerators for the speed scaling divider.
    logic             s3_valid_reg;
    logic [DIV1_NW-1:0] s3_num_x_reg;
    logic [DIV1_NW-1:0] s3_num_y_reg;
    logic [SQ1_N-1:0] s3_den_reg;
    spd_div_side_t    s3_side_reg;
    spd_side_t        sq1_last;
    spd_div_side_t    s3_side_next;

    assign sq1_last = sq1_side[SQ1_N];

    always_comb
    begin
        s3_side_next.held     = sq1_last.held;
        s3_side_next.spd_over = sq1_last.spd_over;
        s3_side_next.rot_cap  = sq1_last.rot_cap;
        s3_side_next.sgn_x    = sq1_last.sgn_x;
        s3_side_next.sgn_y    = sq1_last.sgn_y;
        s3_side_next.vx       = sq1_last.vx;
        s3_side_next.vy       = sq1_last.vy;
        s3_side_next.rot      = sq1_last.rot;
        s3_side_next.cx       = sq1_last.cx;
        s3_side_next.cy       = sq1_last.cy;
        s3_side_next.cr       = sq1_last.cr;
        s3_side_next.t        = sq1_last.t;
    end

    always_ff @(posedge clk)
    begin
        s3_num_x_reg <= {sq1_last.nx, 8'h00} + DIV1_NW'(sq1_root[SQ1_N][SQ1_N-1:1]);
        s3_num_y_reg <= {sq1_last.ny, 8'h00} + DIV1_NW'(sq1_root[SQ1_N][SQ1_N-1:1]);
        s3_den_reg   <= sq1_root[SQ1_N];
        s3_side_reg  <= s3_side_next;
    end

    // ------------------------------------------------------------------
    // Speed scaling divider chain.
    logic               dv1_valid [0:DIV1_Q];
    logic [DIV1_NW-1:0] dv1_nx    [0:DIV1_Q];
    logic [DIV1_NW-1:0] dv1_ny    [0:DIV1_Q];
    logic [SQ1_N-1:0]   dv1_den   [0:DIV1_Q];
    logic [DIV1_Q-1:0]  dv1_qx    [0:DIV1_Q];
    logic [DIV1_Q-1:0]  dv1_qy    [0:DIV1_Q];
    spd_div_side_t      dv1_side  [0:DIV1_Q];

    assign dv1_valid[0] = s3_valid_reg;
    assign dv1_nx[0]    = s3_num_x_reg;
    assign dv1_ny[0]    = s3_num_y_reg;
    assign dv1_den[0]   = s3_den_reg;
    assign dv1_qx[0]    = '0;
    assign dv1_qy[0]    = '0;
    assign dv1_side[0]  = s3_side_reg;

    for (genvar g = 0; g < DIV1_Q; g++)
    begin : g_dv1
        vcl_div_cell #(
            .NW    (DIV1_NW),
            .VW    (SQ1_N),
            .QW    (DIV1_Q),
            .SHIFT (DIV1_Q - 1 - g),
            .SW    ($bits(spd_div_side_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv1_valid[g]),
            .in_num_x  (dv1_nx[g]),
            .in_num_y  (dv1_ny[g]),
            .in_den    (dv1_den[g]),
            .in_qx     (dv1_qx[g]),
            .in_qy     (dv1_qy[g]),
            .in_side   (dv1_side[g]),
            .out_valid (dv1_valid[g+1]),
            .out_num_x (dv1_nx[g+1]),
            .out_num_y (dv1_ny[g+1]),
            .out_den   (dv1_den[g+1]),
            .out_qx    (dv1_qx[g+1]),
            .out_qy    (dv1_qy[g+1]),
            .out_side  (dv1_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage 4: speed limited vector and the step allowances.
    logic               s4_valid_reg;
    logic signed [15:0] s4_vx_reg;
    logic signed [15:0] s4_vy_reg;
    logic signed [15:0] s4_rot_reg;
    logic signed [15:0] s4_cx_reg;
    logic signed [15:0] s4_cy_reg;
    logic signed [15:0] s4_cr_reg;
    logic               s4_held_reg;
    logic               s4_scap_reg;
    logic [30:0]        s4_m_reg;
    logic [30:0]        s4_mr_reg;
    spd_div_side_t      dv1_last;
    logic signed [15:0] q1x;
    logic signed [15:0] q1y;

    assign dv1_last = dv1_side[DIV1_Q];
    assign q1x      = dv1_qx[DIV1_Q];
    assign q1y      = dv1_qy[DIV1_Q];

    always_ff @(posedge clk)
    begin
        s4_vx_reg   <= dv1_last.spd_over ? (dv1_last.sgn_x ? -q1x : q1x) : dv1_last.vx;
        s4_vy_reg   <= dv1_last.spd_over ? (dv1_last.sgn_y ? -q1y : q1y) : dv1_last.vy;
        s4_rot_reg  <= dv1_last.rot;
        s4_cx_reg   <= dv1_last.cx;
        s4_cy_reg   <= dv1_last.cy;
        s4_cr_reg   <= dv1_last.cr;
        s4_held_reg <= dv1_last.held;
        s4_scap_reg <= dv1_last.spd_over | dv1_last.rot_cap;
        s4_m_reg    <= accel_limit_reg * dv1_last.t;
        s4_mr_reg   <= turn_accel_limit_reg * dv1_last.t;
    end

    // ------------------------------------------------------------------
    // Stage 5: velocity change and the rotational acceleration cap.
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [17:0] dr;
    logic [17:0]        abs_dr;
    logic [31:0]        mr_round;
    logic               ra_over;
    logic signed [18:0] step_r;
    logic signed [18:0] rot_n;
    logic               s5_valid_reg;
    logic signed [17:0] s5_dx_reg;
    logic signed [17:0] s5_dy_reg;
    logic signed [18:0] s5_rot_reg;
    logic signed [15:0] s5_vx_reg;
    logic signed [15:0] s5_vy_reg;
    logic signed [15:0] s5_cx_reg;
    logic signed [15:0] s5_cy_reg;
    logic signed [15:0] s5_cr_reg;
    logic               s5_held_reg;
    logic               s5_scap_reg;
    logic               s5_ra_reg;
    logic [30:0]        s5_m_reg;

    assign dx       = 18'(s4_vx_reg) - 18'(s4_cx_reg);
    assign dy       = 18'(s4_vy_reg) - 18'(s4_cy_reg);
    assign dr       = 18'(s4_rot_reg) - 18'(s4_cr_reg);
    assign abs_dr   = dr[17] ? (~dr + 18'd1) : dr;
    assign ra_over  = (abs_dr > {3'b000, s4_mr_reg[30:16]});
    assign mr_round = {1'b0, s4_mr_reg} + 32'd32768;
    assign step_r   = {3'b000, mr_round[31:16]};
    assign rot_n    = ra_over ? (dr[17] ? 19'(s4_cr_reg) - step_r : 19'(s4_cr_reg) + step_r)
                              : 19'(s4_rot_reg);

    always_ff @(posedge clk)
    begin
        s5_dx_reg   <= dx;
        s5_dy_reg   <= dy;
        s5_rot_reg  <= rot_n;
        s5_vx_reg   <= s4_vx_reg;
        s5_vy_reg   <= s4_vy_reg;
        s5_cx_reg   <= s4_cx_reg;
        s5_cy_reg   <= s4_cy_reg;
        s5_cr_reg   <= s4_cr_reg;
        s5_held_reg <= s4_held_reg;
        s5_scap_reg <= s4_scap_reg;
        s5_ra_reg   <= ra_over;
        s5_m_reg    <= s4_m_reg;
    end

    // ------------------------------------------------------------------
    // Stage 6: squared change, squared allowance, step numerators.
    logic signed [35:0] dxsq;
    logic signed [35:0] dysq;
    logic [17:0]        abs_dx;
    logic [17:0]        abs_dy;
    logic               s6_valid_reg;
    logic [31:0]        s6_dxsq_reg;
    logic [31:0]        s6_dysq_reg;
    logic [61:0]        s6_m2_reg;
    acc_side_t          s6_side_reg;
    acc_side_t          s6_side_next;

    assign dxsq   = s5_dx_reg * s5_dx_reg;
    assign dysq   = s5_dy_reg * s5_dy_reg;
    assign abs_dx = s5_dx_reg[17] ? (~s5_dx_reg + 18'd1) : s5_dx_reg;
    assign abs_dy = s5_dy_reg[17] ? (~s5_dy_reg + 18'd1) : s5_dy_reg;

    always_comb
    begin
        s6_side_next         = '0;
        s6_side_next.held    = s5_held_reg;
        s6_side_next.scap    = s5_scap_reg;
        s6_side_next.ra_over = s5_ra_reg;
        s6_side_next.sgn_x   = s5_dx_reg[17];
        s6_side_next.sgn_y   = s5_dy_reg[17];
        s6_side_next.vx      = s5_vx_reg;
        s6_side_next.vy      = s5_vy_reg;
        s6_side_next.cx      = s5_cx_reg;
        s6_side_next.cy      = s5_cy_reg;
        s6_side_next.rot     = s5_held_reg ? s5_cr_reg : sat16(20'(s5_rot_reg));
        s6_side_next.ax      = abs_dx[15:0] * s5_m_reg;
        s6_side_next.ay      = abs_dy[15:0] * s5_m_reg;
    end

    always_ff @(posedge clk)
    begin
        s6_dxsq_reg <= dxsq[31:0];
        s6_dysq_reg <= dysq[31:0];
        s6_m2_reg   <= s5_m_reg * s5_m_reg;
        s6_side_reg <= s6_side_next;
    end

    // ------------------------------------------------------------------
    // Stage 7: squared change length and the translational cap test.
    logic        s7_valid_reg;
    logic [32:0] s7_d2_reg;
    acc_side_t   s7_side_reg;
    acc_side_t   s7_side_next;
    logic [32:0] d2;

    assign d2 = {1'b0, s6_dxsq_reg} + {1'b0, s6_dysq_reg};

    always_comb
    begin
        s7_side_next         = s6_side_reg;
        s7_side_next.tr_over = (d2 > {3'b000, s6_m2_reg[61:32]});
    end

    always_ff @(posedge clk)
    begin
        s7_d2_reg   <= d2;
        s7_side_reg <= s7_side_next;
    end

    // ------------------------------------------------------------------
    // Velocity change magnitude root chain.
    logic               sq2_valid [0:SQ2_N];
    logic [2*SQ2_N-1:0] sq2_rad   [0:SQ2_N];
    logic [SQ2_N:0]     sq2_rem   [0:SQ2_N];
    logic [SQ2_N-1:0]   sq2_root  [0:SQ2_N];
    acc_side_t          sq2_side  [0:SQ2_N];

    assign sq2_valid[0] = s7_valid_reg;
    assign sq2_rad[0]   = {1'b0, s7_d2_reg, 16'h0000};
    assign sq2_rem[0]   = '0;
    assign sq2_root[0]  = '0;
    assign sq2_side[0]  = s7_side_reg;

    for (genvar g = 0; g < SQ2_N; g++)
    begin : g_sq2
        vcl_sqrt_cell #(
            .N  (SQ2_N),
            .SW ($bits(acc_side_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq2_valid[g]),
            .in_rad    (sq2_rad[g]),
            .in_rem    (sq2_rem[g]),
            .in_root   (sq2_root[g]),
            .in_side   (sq2_side[g]),
            .out_valid (sq2_valid[g+1]),
            .out_rad   (sq2_rad[g+1]),
            .out_rem   (sq2_rem[g+1]),
            .out_root  (sq2_root[g+1]),
            .out_side  (sq2_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage 8: divisor and rounded numerators of the acceleration step.
    logic               s8_valid_reg;
    logic [DIV2_NW-1:0] s8_num_x_reg;
    logic [DIV2_NW-1:0] s8_num_y_reg;
    logic [DIV2_VW-1:0] s8_den_reg;
    acc_div_side_t      s8_side_reg;
    acc_side_t          sq2_last;
    acc_div_side_t      s8_side_next;
    logic [DIV2_NW-1:0] half_den;

    assign sq2_last = sq2_side[SQ2_N];
    assign half_den = DIV2_NW'({sq2_root[SQ2_N], 7'h00});

    always_comb
    begin
        s8_side_next.held    = sq2_last.held;
        s8_side_next.scap    = sq2_last.scap;
        s8_side_next.ra_over = sq2_last.ra_over;
        s8_side_next.tr_over = sq2_last.tr_over;
        s8_side_next.sgn_x   = sq2_last.sgn_x;
        s8_side_next.sgn_y   = sq2_last.sgn_y;
        s8_side_next.vx      = sq2_last.vx;
        s8_side_next.vy      = sq2_last.vy;
        s8_side_next.cx      = sq2_last.cx;
        s8_side_next.cy      = sq2_last.cy;
        s8_side_next.rot     = sq2_last.rot;
    end

    always_ff @(posedge clk)
    begin
        s8_num_x_reg <= DIV2_NW'(sq2_last.ax) + half_den;
        s8_num_y_reg <= DIV2_NW'(sq2_last.ay) + half_den;
        s8_den_reg   <= {sq2_root[SQ2_N], 8'h00};
        s8_side_reg  <= s8_side_next;
    end

    // ------------------------------------------------------------------
    // Acceleration step divider chain.
    logic               dv2_valid [0:DIV2_Q];
    logic [DIV2_NW-1:0] dv2_nx    [0:DIV2_Q];
    logic [DIV2_NW-1:0] dv2_ny    [0:DIV2_Q];
    logic [DIV2_VW-1:0] dv2_den   [0:DIV2_Q];
    logic [DIV2_Q-1:0]  dv2_qx    [0:DIV2_Q];
    logic [DIV2_Q-1:0]  dv2_qy    [0:DIV2_Q];
    acc_div_side_t      dv2_side  [0:DIV2_Q];

    assign dv2_valid[0] = s8_valid_reg;
    assign dv2_nx[0]    = s8_num_x_reg;
    assign dv2_ny[0]    = s8_num_y_reg;
    assign dv2_den[0]   = s8_den_reg;
    assign dv2_qx[0]    = '0;
    assign dv2_qy[0]    = '0;
    assign dv2_side[0]  = s8_side_reg;

    for (genvar g = 0; g < DIV2_Q; g++)
    begin : g_dv2
        vcl_div_cell #(
            .NW    (DIV2_NW),
            .VW    (DIV2_VW),
            .QW    (DIV2_Q),
            .SHIFT (DIV2_Q - 1 - g),
            .SW    ($bits(acc_div_side_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv2_valid[g]),
            .in_num_x  (dv2_nx[g]),
            .in_num_y  (dv2_ny[g]),
            .in_den    (dv2_den[g]),
            .in_qx     (dv2_qx[g]),
            .in_qy     (dv2_qy[g]),
            .in_side   (dv2_side[g]),
            .out_valid (dv2_valid[g+1]),
            .out_num_x (dv2_nx[g+1]),
            .out_num_y (dv2_ny[g+1]),
            .out_den   (dv2_den[g+1]),
            .out_qx    (dv2_qx[g+1]),
            .out_qy    (dv2_qy[g+1]),
            .out_side  (dv2_side[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: apply the translational step, saturate and flag.
    acc_div_side_t      dv2_last;
    logic signed [19:0] q2x;
    logic signed [19:0] q2y;
    logic signed [19:0] sum_x;
    logic signed [19:0] sum_y;
    logic               out_valid_reg;
    logic signed [15:0] out_vx_reg;
    logic signed [15:0] out_vy_reg;
    logic signed [15:0] out_rot_reg;
    logic               speed_capped_reg;
    logic               accel_capped_reg;
    logic               held_current_reg;

    assign dv2_last = dv2_side[DIV2_Q];
    assign q2x      = {2'b00, dv2_qx[DIV2_Q]};
    assign q2y      = {2'b00, dv2_qy[DIV2_Q]};
    assign sum_x    = dv2_last.sgn_x ? 20'(dv2_last.cx) - q2x : 20'(dv2_last.cx) + q2x;
    assign sum_y    = dv2_last.sgn_y ? 20'(dv2_last.cy) - q2y : 20'(dv2_last.cy) + q2y;

    always_ff @(posedge clk)
    begin
        if (dv2_last.held)
        begin
            out_vx_reg <= dv2_last.cx;
            out_vy_reg <= dv2_last.cy;
        end
        else if (dv2_last.tr_over)
        begin
            out_vx_reg <= sat16(sum_x);
            out_vy_reg <= sat16(sum_y);
        end
        else
        begin
            out_vx_reg <= dv2_last.vx;
            out_vy_reg <= dv2_last.vy;
        end
        out_rot_reg      <= dv2_last.rot;
        speed_capped_reg <= ~dv2_last.held & dv2_last.scap;
        accel_capped_reg <= ~dv2_last.held & (dv2_last.tr_over | dv2_last.ra_over);
        held_current_reg <= dv2_last.held;
    end

    // ------------------------------------------------------------------
    // Valid flags of the arithmetic stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_acc;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= sq1_valid[SQ1_N];
            s4_valid_reg  <= dv1_valid[DIV1_Q];
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= sq2_valid[SQ2_N];
            out_valid_reg <= dv2_valid[DIV2_Q];
        end
    end

    assign done         = out_valid_reg;
    assign out_vx       = out_vx_reg;
    assign out_vy       = out_vy_reg;
    assign out_rot      = out_rot_reg;
    assign speed_capped = speed_capped_reg;
    assign accel_capped = accel_capped_reg;
    assign held_current = held_current_reg;

`ifndef SYNTH
    // Every accepted beat yields exactly one result strobe.
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(in_acc, LAT))
        else $error("result strobe does not match accepted beats");

    // A held result never reports a cap.
    a_held_flags : assert property (@(posedge clk) disable iff (!rst_n)
        done && held_current |-> !speed_capped && !accel_capped)
        else $error("cap flag raised on a held result");

    // The speed scaling divisor is non-zero whenever it is used.
    a_spd_den : assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && s3_side_reg.spd_over |-> s3_den_reg != '0)
        else $error("zero speed magnitude on a capped command");

    // The acceleration step divisor is non-zero whenever it is used.
    a_acc_den : assert property (@(posedge clk) disable iff (!rst_n)
        s8_valid_reg && s8_side_reg.tr_over |-> s8_den_reg != '0)
        else $error("zero change magnitude on a capped step");
`endif

endmodule
`default_nettype wire
